>>> src/whp_pkg.sv
// Shared types, codes and constants of the WAV header parser.
package whp_pkg;

   // Parse phase of the header walk.
   typedef enum logic [4:0] {
      PH_IDLE,
      PH_RIFF_TAG,
      PH_RIFF_SIZE,
      PH_WAVE_TAG,
      PH_FMT_TAG,
      PH_FMT_SIZE,
      PH_FORMAT,
      PH_CHANNELS,
      PH_RATE,
      PH_AVG,
      PH_ALIGN,
      PH_BITS,
      PH_EXTRA,
      PH_CHUNK_TAG,
      PH_FACT_SIZE,
      PH_FACT_PAYLOAD,
      PH_DATA_TAG,
      PH_DATA_SIZE
   } phase_type;

   // State of the result side.
   typedef enum logic [1:0] {
      RS_EMPTY,
      RS_DIVIDE,
      RS_HOLD
   } res_type;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
   localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
   localparam logic [2:0] ST_BAD_FMT   = 3'd3;
   localparam logic [2:0] ST_BAD_DATA  = 3'd4;
   localparam logic [2:0] ST_FMT_SHORT = 3'd5;

   // Chunk tags as little-endian words.
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_FACT = 32'h7463_6166;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
   localparam logic [31:0] RIFF_HDR_ADD = 32'd8;

   // Divider steps, one quotient bit each.
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       restart;
      logic       step;
      logic       skip_dec;
      logic       half_field;
      logic       cap_riff;
      logic       set_skip;
      logic       cap_format;
      logic       cap_chan;
      logic       cap_rate;
      logic       cap_align;
      logic       cap_bits;
      logic       load_ok;
      logic       load_err;
      logic [2:0] err_code;
      logic       load_count;
   } whp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic field_done;
      logic is_riff;
      logic is_wave;
      logic is_fmt;
      logic is_fact;
      logic is_data;
      logic fmt_short;
      logic skip_last;
      logic skip_zero;
      logic div_done;
   } whp_stat_type;

endpackage

>>> src/whp_divider.sv
// Restoring divider, one quotient bit per cycle, giving zero for a zero divisor.
module whp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import whp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          quo_ff, quo_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          div_ff, div_in;
   logic                 zero_ff, zero_in;
   logic [16:0]          partial;
   logic [16:0]          diff;
   logic                 ge;

   // One shift-and-subtract step.
   assign partial = {rem_ff, quo_ff[31]};
   assign diff    = partial - {1'b0, div_ff};
   assign ge      = (partial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         zero_in = (divisor == 16'd0);
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], ge};
         rem_in = ge ? diff[15:0] : partial[15:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      zero_ff <= zero_in;
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? 32'd0 : quo_ff;

endmodule

>>> src/whp_datapath.sv
// Byte assembly, field capture, position count and result registers.
module whp_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          data_byte,
   input  whp_pkg::whp_cmd_type cmd,
   output whp_pkg::whp_stat_type stat,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_total_size,
   output logic [15:0]         rsp_format_tag,
   output logic [15:0]         rsp_channel_count,
   output logic [31:0]         rsp_sample_rate,
   output logic [15:0]         rsp_block_align,
   output logic [15:0]         rsp_bits_per_sample,
   output logic [31:0]         rsp_data_size,
   output logic [31:0]         rsp_data_offset,
   output logic [31:0]         rsp_block_count
);
   import whp_pkg::*;

   logic [1:0]  idx_ff, idx_in, idx_eff;
   logic [31:0] asm_ff, asm_in, asm_eff;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] skip_ff;
   logic [31:0] riff_ff;
   logic [15:0] format_ff, chan_ff, align_ff, bits_ff;
   logic [31:0] rate_ff;
   logic [31:0] word;
   logic        div_done;
   logic [31:0] quotient;

   // A start byte sees a cleared assembly.
   assign idx_eff = cmd.restart ? 2'd0 : idx_ff;
   assign asm_eff = cmd.restart ? 32'd0 : asm_ff;

   // Place the byte into its lane of the little-endian word.
   always_comb begin
      word = asm_eff;
      case (idx_eff)
         2'd0:    word[7:0]   = data_byte;
         2'd1:    word[15:8]  = data_byte;
         2'd2:    word[23:16] = data_byte;
         2'd3:    word[31:24] = data_byte;
         default: word = asm_eff;
      endcase
   end

   // Status toward the controller.
   always_comb begin
      stat.field_done = cmd.half_field ? (idx_eff == 2'd1) : (idx_eff == 2'd3);
      stat.is_riff    = (word == TAG_RIFF);
      stat.is_wave    = (word == TAG_WAVE);
      stat.is_fmt     = (word == TAG_FMT);
      stat.is_fact    = (word == TAG_FACT);
      stat.is_data    = (word == TAG_DATA);
      stat.fmt_short  = (word < FMT_MIN_SIZE);
      stat.skip_last  = (skip_ff == 32'd1);
      stat.skip_zero  = (skip_ff == 32'd0);
      stat.div_done   = div_done;
   end

   // Next assembly index, word and byte position.
   always_comb begin
      idx_in = idx_ff;
      asm_in = asm_ff;
      pos_in = pos_ff;
      if (cmd.restart) begin
         idx_in = '0;
         asm_in = '0;
         pos_in = '0;
      end
      if (cmd.step) begin
         pos_in = (cmd.restart ? 32'd0 : pos_ff) + 32'd1;
         if (!cmd.skip_dec) begin
            if (stat.field_done) begin
               idx_in = '0;
               asm_in = '0;
            end else begin
               idx_in = idx_eff + 2'd1;
               asm_in = word;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         asm_ff <= '0;
         pos_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         asm_ff <= asm_in;
         pos_ff <= pos_in;
      end
   end

   // Header field captures and the extra fmt byte counter.
   always_ff @(posedge clock) begin
      if (cmd.set_skip)   skip_ff   <= word - FMT_MIN_SIZE;
      else if (cmd.skip_dec) skip_ff <= skip_ff - 32'd1;
      if (cmd.cap_riff)   riff_ff   <= word;
      if (cmd.cap_format) format_ff <= word[15:0];
      if (cmd.cap_chan)   chan_ff   <= word[15:0];
      if (cmd.cap_rate)   rate_ff   <= word;
      if (cmd.cap_align)  align_ff  <= word[15:0];
      if (cmd.cap_bits)   bits_ff   <= word[15:0];
   end

   // Result registers: all zero but status for an error.
   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         rsp_status          <= cmd.err_code;
         rsp_total_size      <= '0;
         rsp_format_tag      <= '0;
         rsp_channel_count   <= '0;
         rsp_sample_rate     <= '0;
         rsp_block_align     <= '0;
         rsp_bits_per_sample <= '0;
         rsp_data_size       <= '0;
         rsp_data_offset     <= '0;
         rsp_block_count     <= '0;
      end else if (cmd.load_ok) begin
         rsp_status          <= ST_OK;
         rsp_total_size      <= riff_ff + RIFF_HDR_ADD;
         rsp_format_tag      <= format_ff;
         rsp_channel_count   <= chan_ff;
         rsp_sample_rate     <= rate_ff;
         rsp_block_align     <= align_ff;
         rsp_bits_per_sample <= bits_ff;
         rsp_data_size       <= word;
         rsp_data_offset     <= pos_in;
      end else if (cmd.load_count) begin
         rsp_block_count <= quotient;
      end
   end

   // Block count division runs once per file.
   whp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load_ok),
      .dividend (word),
      .divisor  (align_ff),
      .done     (div_done),
      .quotient (quotient)
   );

endmodule

>>> src/whp_ctrl.sv
// Controller: header phase sequencing and result handshake.
module whp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_start_req,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  whp_pkg::whp_stat_type stat,
   output whp_pkg::whp_cmd_type  cmd
);
   import whp_pkg::*;

   phase_type phase_ff, phase_in, phase_eff;
   res_type   res_ff, res_in;
   logic      accept;
   logic      restart;
   logic      step;

   // Input is taken only while no result is pending.
   assign req_stall = (res_ff != RS_EMPTY);
   assign rsp_valid = (res_ff == RS_HOLD);
   assign accept    = req_valid && !req_stall;
   assign restart   = accept && req_start_req;
   assign phase_eff = restart ? PH_RIFF_TAG : phase_ff;
   assign step      = accept && (phase_eff != PH_IDLE);

   // Commands for the current byte.
   always_comb begin
      cmd            = '0;
      cmd.restart    = restart;
      cmd.step       = step;
      cmd.load_count = (res_ff == RS_DIVIDE) && stat.div_done;
      if (step) begin
         case (phase_eff)
            PH_EXTRA:                                    cmd.skip_dec = 1'b1;
            PH_FORMAT, PH_CHANNELS, PH_ALIGN, PH_BITS:   cmd.half_field = 1'b1;
            default:                                     cmd.half_field = 1'b0;
         endcase
         if (stat.field_done && phase_eff != PH_EXTRA) begin
            case (phase_eff)
               PH_RIFF_TAG: begin
                  cmd.load_err = !stat.is_riff;
                  cmd.err_code = ST_BAD_RIFF;
               end
               PH_RIFF_SIZE: cmd.cap_riff = 1'b1;
               PH_WAVE_TAG: begin
                  cmd.load_err = !stat.is_wave;
                  cmd.err_code = ST_BAD_WAVE;
               end
               PH_FMT_TAG: begin
                  cmd.load_err = !stat.is_fmt;
                  cmd.err_code = ST_BAD_FMT;
               end
               PH_FMT_SIZE: begin
                  cmd.load_err = stat.fmt_short;
                  cmd.err_code = ST_FMT_SHORT;
                  cmd.set_skip = !stat.fmt_short;
               end
               PH_FORMAT:   cmd.cap_format = 1'b1;
               PH_CHANNELS: cmd.cap_chan = 1'b1;
               PH_RATE:     cmd.cap_rate = 1'b1;
               PH_ALIGN:    cmd.cap_align = 1'b1;
               PH_BITS:     cmd.cap_bits = 1'b1;
               PH_CHUNK_TAG: begin
                  cmd.load_err = !stat.is_fact && !stat.is_data;
                  cmd.err_code = ST_BAD_DATA;
               end
               PH_DATA_TAG: begin
                  cmd.load_err = !stat.is_data;
                  cmd.err_code = ST_BAD_DATA;
               end
               PH_DATA_SIZE: cmd.load_ok = 1'b1;
               default:      cmd.load_err = 1'b0;
            endcase
         end
      end
   end

   // Next parse phase.
   always_comb begin
      phase_in = phase_eff;
      if (step) begin
         if (phase_eff == PH_EXTRA) begin
            if (stat.skip_last) phase_in = PH_CHUNK_TAG;
         end else if (stat.field_done) begin
            case (phase_eff)
               PH_RIFF_TAG:     phase_in = PH_RIFF_SIZE;
               PH_RIFF_SIZE:    phase_in = PH_WAVE_TAG;
               PH_WAVE_TAG:     phase_in = PH_FMT_TAG;
               PH_FMT_TAG:      phase_in = PH_FMT_SIZE;
               PH_FMT_SIZE:     phase_in = PH_FORMAT;
               PH_FORMAT:       phase_in = PH_CHANNELS;
               PH_CHANNELS:     phase_in = PH_RATE;
               PH_RATE:         phase_in = PH_AVG;
               PH_AVG:          phase_in = PH_ALIGN;
               PH_ALIGN:        phase_in = PH_BITS;
               PH_BITS:         phase_in = stat.skip_zero ? PH_CHUNK_TAG : PH_EXTRA;
               PH_CHUNK_TAG:    phase_in = stat.is_fact ? PH_FACT_SIZE : PH_DATA_SIZE;
               PH_FACT_SIZE:    phase_in = PH_FACT_PAYLOAD;
               PH_FACT_PAYLOAD: phase_in = PH_DATA_TAG;
               PH_DATA_TAG:     phase_in = PH_DATA_SIZE;
               default:         phase_in = PH_IDLE;
            endcase
            if (cmd.load_err) phase_in = PH_IDLE;
         end
      end
   end

   // Next result state.
   always_comb begin
      res_in = res_ff;
      case (res_ff)
         RS_EMPTY: begin
            if (cmd.load_err)     res_in = RS_HOLD;
            else if (cmd.load_ok) res_in = RS_DIVIDE;
         end
         RS_DIVIDE: if (stat.div_done) res_in = RS_HOLD;
         RS_HOLD:   if (!rsp_stall) res_in = RS_EMPTY;
         default:   res_in = RS_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         res_ff   <= RS_EMPTY;
      end else begin
         phase_ff <= phase_in;
         res_ff   <= res_in;
      end
   end

endmodule

>>> src/wav_header_parser_core.sv
// Top level of the RIFF/WAVE header parser.
// Header bytes are taken at one per cycle; each byte is one item.
// An error result is shown the cycle after the offending byte; an ok result
// appears after the last data size byte once the bit-serial block count
// divider is done. Input is stalled while a result is pending.
// Synchronous active-high reset returns the parser to idle awaiting a start.
module wav_header_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_total_size,
   output logic [15:0] rsp_format_tag,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_block_align,
   output logic [15:0] rsp_bits_per_sample,
   output logic [31:0] rsp_data_size,
   output logic [31:0] rsp_data_offset,
   output logic [31:0] rsp_block_count
);
   import whp_pkg::*;

   whp_cmd_type  cmd;
   whp_stat_type stat;

   // Phase sequencing and handshakes.
   whp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Field assembly and result registers.
   whp_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .data_byte           (req_data_byte),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_status          (rsp_status),
      .rsp_total_size      (rsp_total_size),
      .rsp_format_tag      (rsp_format_tag),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_block_align     (rsp_block_align),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_data_size       (rsp_data_size),
      .rsp_data_offset     (rsp_data_offset),
      .rsp_block_count     (rsp_block_count)
   );

   // A pending result always holds off new input.
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input not stalled while a result is pending");

   // A taken result frees the output the next cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result repeated after it was taken");

   // Error results carry zero header values.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_total_size == 32'd0 &&
         rsp_block_count == 32'd0 && rsp_data_offset == 32'd0)
      else $error("error result with nonzero fields");

   // A zero block align gives a zero block count.
   a_zero_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_align == 16'd0 |-> rsp_block_count == 32'd0)
      else $error("nonzero block count for zero block align");

endmodule
